// ===== sv/wto_pkg.sv =====
// Shared types, codes and constants for the wavetable oscillator.
`default_nettype none
package wto_pkg;

    // Default sizes
    localparam int DEF_TABLE_DEPTH   = 256;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_SAMPLE_BITS   = 16;

    // Fixed field widths
    localparam int ACTION_BITS     = 2;
    localparam int ADDRESS_BITS    = 8;
    localparam int VALUE_BITS      = 16;
    localparam int PHASE_STEP_BITS = 24;
    localparam int AMP_BITS        = 16;
    localparam int AMP_SHIFT       = 15;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 24;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE  = CFG_INDEX_BITS'(1);

    // Item action codes
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_TICK      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_SWAP      = 2'd2,
        ACT_PHASE_CLR = 2'd3
    } action_t;

    // Tick sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_BLEND,
        ST_SCALE,
        ST_OUT
    } state_t;

    // Datapath strobes from the sequencer
    typedef struct packed {
        logic tick_start;
        logic cap_a;
        logic mul_en;
        logic mul_scale;
        logic out_load;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== sv/wto_table_ram.sv =====
// Double-bank waveform table memory, one write port and one registered read port.
`default_nettype none
module wto_table_ram #(
    parameter int DEPTH = 2 * wto_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = wto_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write shadow entries, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/wto_mul_unit.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module wto_mul_unit #(
    parameter int A_BITS = wto_pkg::DEF_SAMPLE_BITS + 1,
    parameter int B_BITS = wto_pkg::DEF_FRACTION_BITS + 1
) (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic signed [A_BITS-1:0]        op_a,
    input  wire logic signed [B_BITS-1:0]        op_b,
    output logic      signed [A_BITS+B_BITS-1:0] prod_reg
);

    // Capture the product when enabled
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

endmodule
`default_nettype wire

// ===== sv/wto_ctrl.sv =====
// Tick sequencer: steps the reads and the two multiplies of one sample.
`default_nettype none
module wto_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic [wto_pkg::ACTION_BITS-1:0]  s_action,
    input  wire logic                             out_free,
    output logic                                  s_ready,
    output wto_pkg::ctrl_t                        ctrl
);

    wto_pkg::state_t state_reg;
    wto_pkg::state_t state_next;
    logic            tick_req;

    assign tick_req = s_valid && (s_action == wto_pkg::ACT_TICK);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wto_pkg::ST_IDLE: begin
                if (tick_req) begin
                    state_next = wto_pkg::ST_READ_B;
                end
            end
            wto_pkg::ST_READ_B: state_next = wto_pkg::ST_BLEND;
            wto_pkg::ST_BLEND:  state_next = wto_pkg::ST_SCALE;
            wto_pkg::ST_SCALE:  state_next = wto_pkg::ST_OUT;
            wto_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = wto_pkg::ST_IDLE;
                end
            end
            default: state_next = wto_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = 1'b0;
        ctrl    = '0;
        case (state_reg)
            wto_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                ctrl.tick_start = tick_req;
            end
            wto_pkg::ST_READ_B: ctrl.cap_a = 1'b1;
            wto_pkg::ST_BLEND: begin
                ctrl.mul_en = 1'b1;
            end
            wto_pkg::ST_SCALE: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_scale = 1'b1;
            end
            wto_pkg::ST_OUT: ctrl.out_load = out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wto_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/wavetable_oscillator_linear_interp_core.sv =====
// Wavetable oscillator with linear interpolation: registers, datapath and output stage.
// A tick's sample steps through READ_B, BLEND, SCALE and OUT into the sample register,
// waiting in OUT while that register holds an untaken sample. The single read port (two
// entries) and the shared multiplier (blend, then gain) hold off new items during a tick;
// write, swap and phase clear are taken while idle. The sample register lets the next item
// in while a sample waits to be taken. Reset (aresetn low, synchronous) clears phase, bank
// select, swap flag, registers and handshake state; table contents are undefined until written.
`default_nettype none
module wavetable_oscillator_linear_interp_core #(
    parameter int TABLE_DEPTH   = wto_pkg::DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = wto_pkg::DEF_FRACTION_BITS,
    parameter int SAMPLE_BITS   = wto_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input items
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [wto_pkg::ACTION_BITS-1:0]      s_action,
    input  wire logic [wto_pkg::ADDRESS_BITS-1:0]     s_table_address,
    input  wire logic signed [wto_pkg::VALUE_BITS-1:0] s_table_value,
    // Result items
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]             m_sample,
    // Register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [wto_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [wto_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PW    = AW + FRACTION_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int MB    = ((FRACTION_BITS > wto_pkg::AMP_BITS) ?
                            FRACTION_BITS : wto_pkg::AMP_BITS) + 1;
    localparam int PRODW = SB + 1 + MB;
    localparam int AEXT  = (AW > wto_pkg::ADDRESS_BITS) ? AW : wto_pkg::ADDRESS_BITS;
    localparam int SEXT  = (PW > wto_pkg::PHASE_STEP_BITS) ? PW : wto_pkg::PHASE_STEP_BITS;
    localparam int VEXT  = (SB > wto_pkg::VALUE_BITS) ? SB : wto_pkg::VALUE_BITS;

    localparam logic signed [PRODW-1:0] SAT_MAX = {{(PRODW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PRODW-1:0] SAT_MIN = {{(PRODW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    wto_pkg::ctrl_t ctrl;

    logic [PW-1:0]                          phase_reg;
    logic                                   active_bank_reg;
    logic                                   swap_pending_reg;
    logic [wto_pkg::PHASE_STEP_BITS-1:0]    phase_step_reg;
    logic [wto_pkg::AMP_BITS-1:0]           amplitude_reg;
    logic signed [SB-1:0]                   a_reg;
    logic                                   m_valid_reg;
    logic signed [SB-1:0]                   m_sample_reg;

    logic                    s_accept;
    logic                    out_free;
    logic                    bank_next;
    logic [AW-1:0]           idx;
    logic [AW-1:0]           nxt;
    logic [AEXT-1:0]         addr_ext;
    logic [SEXT-1:0]         step_ext;
    logic [VEXT-1:0]         value_ext;
    logic                    wr_en;
    logic [AW:0]             wr_addr;
    logic [AW:0]             rd_addr;
    logic [SB-1:0]           rd_data;
    logic signed [SB-1:0]    b_val;
    logic signed [SB:0]      diff;
    logic signed [PRODW-1:0] prod_reg;
    logic signed [PRODW-1:0] blend_shift;
    logic signed [SB:0]      blend;
    logic signed [SB:0]      mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PRODW-1:0] scaled;
    logic signed [SB-1:0]    sample_sat;

    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

    // Sequencer
    wto_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    // Table addressing: entry and its successor, wrapping at the table end
    assign idx       = phase_reg[PW-1:FRACTION_BITS];
    assign nxt       = idx + AW'(1);
    assign bank_next = active_bank_reg ^ swap_pending_reg;
    assign addr_ext  = AEXT'(s_table_address);
    assign value_ext = VEXT'($unsigned(s_table_value));
    assign wr_en     = s_accept && (s_action == wto_pkg::ACT_WRITE);
    assign wr_addr   = {~active_bank_reg, addr_ext[AW-1:0]};
    assign rd_addr   = ctrl.tick_start ? {bank_next, idx} : {active_bank_reg, nxt};

    wto_table_ram #(
        .DEPTH (2 * TABLE_DEPTH),
        .WIDTH (SB)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_ext[SB-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Blend and gain operands for the shared multiplier
    assign b_val       = $signed(rd_data);
    assign diff        = {b_val[SB-1], b_val} - {a_reg[SB-1], a_reg};
    assign blend_shift = prod_reg >>> FRACTION_BITS;
    assign blend       = {a_reg[SB-1], a_reg} + blend_shift[SB:0];
    assign mul_a       = ctrl.mul_scale ? blend : diff;
    assign mul_b       = ctrl.mul_scale ?
                         $signed({{(MB-wto_pkg::AMP_BITS){1'b0}}, amplitude_reg}) :
                         $signed({{(MB-FRACTION_BITS){1'b0}}, phase_reg[FRACTION_BITS-1:0]});

    wto_mul_unit #(
        .A_BITS (SB + 1),
        .B_BITS (MB)
    ) u_mul_unit (
        .aclk     (aclk),
        .en       (ctrl.mul_en),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // Drop the gain fraction and clamp to the sample range
    assign scaled = prod_reg >>> wto_pkg::AMP_SHIFT;
    always_comb begin
        if (scaled > SAT_MAX) begin
            sample_sat = SAT_MAX[SB-1:0];
        end else if (scaled < SAT_MIN) begin
            sample_sat = SAT_MIN[SB-1:0];
        end else begin
            sample_sat = scaled[SB-1:0];
        end
    end

    assign step_ext = SEXT'(phase_step_reg);

    // Phase, bank select and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= '0;
            active_bank_reg  <= 1'b0;
            swap_pending_reg <= 1'b0;
            phase_step_reg   <= '0;
            amplitude_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == wto_pkg::REG_PHASE_STEP) begin
                    phase_step_reg <= cfg_data[wto_pkg::PHASE_STEP_BITS-1:0];
                end
                if (cfg_index == wto_pkg::REG_AMPLITUDE) begin
                    amplitude_reg <= cfg_data[wto_pkg::AMP_BITS-1:0];
                end
            end
            if (s_accept && (s_action == wto_pkg::ACT_SWAP)) begin
                swap_pending_reg <= 1'b1;
            end
            if (s_accept && (s_action == wto_pkg::ACT_PHASE_CLR)) begin
                phase_reg <= '0;
            end
            if (ctrl.tick_start) begin
                active_bank_reg  <= bank_next;
                swap_pending_reg <= 1'b0;
            end
            if (ctrl.out_load) begin
                phase_reg <= phase_reg + step_ext[PW-1:0];
            end
        end
    end

    // Hold the first entry while the second is read
    always_ff @(posedge aclk) begin
        if (ctrl.cap_a) begin
            a_reg <= $signed(rd_data);
        end
    end

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_sample_reg <= sample_sat;
        end
    end

`ifndef SYNTH
    // A loaded sample is offered next cycle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |=> m_valid)
        else $error("sample load did not raise m_valid");

    // Starting a tick consumes any pending swap
    a_swap_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.tick_start |=> !swap_pending_reg)
        else $error("swap still pending after tick start");

    // No new item while a tick is in progress
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.tick_start |=> !s_ready)
        else $error("ready raised during a tick");

    // Bank select changes only at tick start
    a_bank_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.tick_start |=> $stable(active_bank_reg))
        else $error("bank changed outside tick start");

    // Phase moves only on sample load or phase clear
    a_phase_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl.out_load && !(s_accept && (s_action == wto_pkg::ACT_PHASE_CLR)))
        |=> $stable(phase_reg))
        else $error("phase changed unexpectedly");
`endif

endmodule
`default_nettype wire

// ===== sim/wavetable_oscillator_linear_interp_core_tb.sv =====
// Self-checking testbench for the wavetable oscillator core: directed table, then random items.
module wavetable_oscillator_linear_interp_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH    = wto_pkg::DEF_TABLE_DEPTH;
    localparam int FRAC_W       = wto_pkg::DEF_FRACTION_BITS;
    localparam int SAMPLE_W     = wto_pkg::DEF_SAMPLE_BITS;
    localparam int ACT_W        = wto_pkg::ACTION_BITS;
    localparam int IN_ADDR_W    = wto_pkg::ADDRESS_BITS;
    localparam int IN_VALUE_W   = wto_pkg::VALUE_BITS;
    localparam int CFG_IDX_W    = wto_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_W   = wto_pkg::CFG_DATA_BITS;
    localparam int STEP_W       = wto_pkg::PHASE_STEP_BITS;
    localparam int AMP_W        = wto_pkg::AMP_BITS;
    localparam int AMP_SH       = wto_pkg::AMP_SHIFT;
    localparam int ADDR_W       = $clog2(TBL_DEPTH);
    localparam int PHASE_W      = ADDR_W + FRAC_W;
    localparam int IDLE_PCT     = 36;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 300;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 180;
    localparam int REPORT_LIMIT = 10;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        wto_pkg::action_t            act;
        logic [IN_ADDR_W-1:0]        addr;
        logic [IN_VALUE_W-1:0]       val;
        logic [CFG_IDX_W-1:0]        reg_idx;
        logic [CFG_DATA_W-1:0]       reg_data;
        logic                        typed;
        logic [SAMPLE_W-1:0]         sample;
    } dir_row_t;

    // Directed rows: register writes wait for an idle block; typed samples bypass the predictor
    localparam dir_row_t DIRECTED [26] = '{
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h0000},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_AMPLITUDE,  24'd32768,  1'b0, 16'h0000},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_WRITE,     8'd0,   16'h7FFF,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_WRITE,     8'd1,   16'h8000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_SWAP,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_SWAP,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_WRITE,     8'd255, 16'h8000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h7FFF},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'hFF0000, 1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h7FFF},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h8000},
        '{ROW_ITEM, wto_pkg::ACT_PHASE_CLR, 8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_SWAP,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_PHASE_CLR, 8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_AMPLITUDE,  24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h0000},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_AMPLITUDE,  24'h00FFFF, 1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_SWAP,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_PHASE_CLR, 8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h7FFF},
        '{ROW_REG,  wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'hFFFFFF, 1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b1, 16'h8000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000},
        '{ROW_ITEM, wto_pkg::ACT_TICK,      8'd0,   16'h0000,
          wto_pkg::REG_PHASE_STEP, 24'd0,      1'b0, 16'h0000}
    };

    logic                              aclk;
    logic                              aresetn         = 1'b0;
    logic                              s_valid         = 1'b0;
    logic                              s_ready;
    logic [ACT_W-1:0]                  s_action        = wto_pkg::ACT_TICK;
    logic [IN_ADDR_W-1:0]              s_table_address = '0;
    logic signed [IN_VALUE_W-1:0]      s_table_value   = '0;
    logic                              m_valid;
    logic                              m_ready         = 1'b0;
    sample_t                           m_sample;
    logic                              cfg_valid       = 1'b0;
    logic                              cfg_ready;
    logic [CFG_IDX_W-1:0]              cfg_index       = '0;
    logic [CFG_DATA_W-1:0]             cfg_data        = '0;

    // Oscillator predictor state
    logic [PHASE_W-1:0]                osc_phase  = '0;
    logic signed [IN_VALUE_W-1:0]      wave_bank [2][TBL_DEPTH];
    logic                              cur_bank   = 1'b0;
    logic                              swap_armed = 1'b0;
    logic [STEP_W-1:0]                 step_size  = '0;
    logic [AMP_W-1:0]                  amp_gain   = '0;

    sample_t                           expected_samples [$];
    int                                samples_taken  = 0;
    int                                mismatch_count = 0;
    bit                                no_idle        = 1'b0;

    wavetable_oscillator_linear_interp_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_table_address (s_table_address),
        .s_table_value   (s_table_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one accepted item to the oscillator state; queue the sample a tick makes
    function automatic void advance_oscillator(input wto_pkg::action_t act,
                                               input logic [IN_ADDR_W-1:0] addr,
                                               input logic signed [IN_VALUE_W-1:0] val,
                                               input logic typed,
                                               input sample_t typed_sample);
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] nxt;
        longint            a;
        longint            b;
        longint            frac;
        longint            gain;
        longint            blend;
        longint            scaled;
        case (act)
            wto_pkg::ACT_WRITE: wave_bank[~cur_bank][addr[ADDR_W-1:0]] = val;
            wto_pkg::ACT_SWAP: swap_armed = 1'b1;
            wto_pkg::ACT_PHASE_CLR: osc_phase = '0;
            default: begin
                if (swap_armed) begin
                    cur_bank   = ~cur_bank;
                    swap_armed = 1'b0;
                end
                idx    = osc_phase[FRAC_W +: ADDR_W];
                nxt    = idx + ADDR_W'(1);
                a      = wave_bank[cur_bank][idx];
                b      = wave_bank[cur_bank][nxt];
                frac   = osc_phase[FRAC_W-1:0];
                gain   = amp_gain;
                blend  = a + (((b - a) * frac) >>> FRAC_W);
                scaled = (blend * gain) >>> AMP_SH;
                if (scaled > SAMPLE_MAX) begin
                    scaled = SAMPLE_MAX;
                end else if (scaled < SAMPLE_MIN) begin
                    scaled = SAMPLE_MIN;
                end
                expected_samples.push_back(typed ? typed_sample : sample_t'(scaled));
                osc_phase = osc_phase + step_size[PHASE_W-1:0];
            end
        endcase
    endfunction

    // Offer one item after a random gap, hold it until taken, then predict
    task automatic offer_item(input wto_pkg::action_t act, input logic [IN_ADDR_W-1:0] addr,
                              input logic signed [IN_VALUE_W-1:0] val,
                              input logic typed, input sample_t typed_sample);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_table_address <= addr;
        s_table_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_oscillator(act, addr, val, typed, typed_sample);
    endtask

    task automatic offer_random(input wto_pkg::action_t act);
        offer_item(act, IN_ADDR_W'($urandom), IN_VALUE_W'($urandom), 1'b0, '0);
    endtask

    // Drop valid, wait for every sample, then let trailing items finish
    task automatic settle_block();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == wto_pkg::REG_PHASE_STEP) begin
            step_size = data[STEP_W-1:0];
        end else begin
            amp_gain = data[AMP_W-1:0];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls, one long hold once HOLD_AFTER samples have been taken
    initial begin : sample_sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && samples_taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each taken sample with the oldest prediction
    always @(posedge aclk) begin : sample_check
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            samples_taken <= samples_taken + 1;
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: sample %0d arrived with none expected", $time, m_sample);
                end
            end else begin
                want = expected_samples.pop_front();
                if (m_sample !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: sample mismatch: expected %0d, got %0d",
                                 $time, want, m_sample);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0]     new_step;
        logic [AMP_W-1:0]          new_amp;
        logic [IN_ADDR_W-1:0]      base;
        int                        sent;
        int                        pick;
        int                        burst_len;
        bit                        paused;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill both banks so that no tick ever reads an unwritten entry
        for (int i = 0; i < TBL_DEPTH; i++) begin
            offer_item(wto_pkg::ACT_WRITE, IN_ADDR_W'(i), IN_VALUE_W'($urandom), 1'b0, '0);
        end
        offer_random(wto_pkg::ACT_SWAP);
        offer_random(wto_pkg::ACT_TICK);
        for (int i = 0; i < TBL_DEPTH; i++) begin
            offer_item(wto_pkg::ACT_WRITE, IN_ADDR_W'(i), IN_VALUE_W'($urandom), 1'b0, '0);
        end

        // Walk the directed table
        for (int r = 0; r < $size(DIRECTED); r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                settle_block();
                write_register(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
            end else begin
                offer_item(DIRECTED[r].act, DIRECTED[r].addr, DIRECTED[r].val,
                           DIRECTED[r].typed, DIRECTED[r].sample);
            end
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle_block();
            case (ph)
                0: begin
                    new_step = CFG_DATA_W'($urandom_range(1, 24'h03FFFF));
                    new_amp  = 16'h8000;
                end
                2: begin
                    new_step = 24'hFFFFFF;
                    new_amp  = 16'hFFFF;
                end
                3: begin
                    new_step = '0;
                    new_amp  = AMP_W'($urandom_range(0, 32768));
                end
                4: begin
                    new_step = CFG_DATA_W'($urandom_range(1, 24'h00FFFF));
                    new_amp  = AMP_W'($urandom_range(0, 32768));
                end
                default: begin
                    new_step = CFG_DATA_W'($urandom);
                    new_amp  = AMP_W'($urandom);
                end
            endcase
            write_register(wto_pkg::REG_PHASE_STEP, new_step);
            write_register(wto_pkg::REG_AMPLITUDE, CFG_DATA_W'(new_amp));
            no_idle = (ph == 2);
            sent    = 0;
            paused  = 1'b0;
            while (sent < PHASE_ITEMS) begin
                // Hold the sender once until every sample so far has come out
                if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    s_valid <= 1'b0;
                    while (expected_samples.size() != 0) @(posedge aclk);
                    @(posedge aclk);
                end
                pick = $urandom_range(99);
                if (pick < 5) begin
                    // Reload a run of shadow entries, then swap it in
                    burst_len = $urandom_range(4, 12);
                    base      = IN_ADDR_W'($urandom);
                    for (int k = 0; k < burst_len; k++) begin
                        offer_item(wto_pkg::ACT_WRITE, base + IN_ADDR_W'(k),
                                   IN_VALUE_W'($urandom), 1'b0, '0);
                    end
                    offer_random(wto_pkg::ACT_SWAP);
                    sent += burst_len + 1;
                end else begin
                    if (pick < 60) begin
                        offer_random(wto_pkg::ACT_TICK);
                    end else if (pick < 80) begin
                        offer_random(wto_pkg::ACT_WRITE);
                    end else if (pick < 91) begin
                        offer_random(wto_pkg::ACT_SWAP);
                    end else begin
                        offer_random(wto_pkg::ACT_PHASE_CLR);
                    end
                    sent++;
                end
            end
        end
        no_idle = 1'b0;

        settle_block();
        if (mismatch_count == 0) begin
            $display("** wavetable_oscillator_linear_interp_core: PASSED **");
        end else begin
            $display("** wavetable_oscillator_linear_interp_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("** wavetable_oscillator_linear_interp_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wto_pkg.sv
sv/wto_table_ram.sv
sv/wto_mul_unit.sv
sv/wto_ctrl.sv
sv/wavetable_oscillator_linear_interp_core.sv
sim/wavetable_oscillator_linear_interp_core_tb.sv
